/* sv/vma_pkg.sv */
package vma_pkg;

  // lane count is fixed by the one-port-per-lane payload
  localparam int LANES = 8;

  // configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

  localparam int WIN_LEN_BITS  = 7;
  localparam int WIN_LEN_RESET = 50;

  // upper bounds for MAX_WINDOW up to 256
  localparam int SLOT_MAX_BITS = 8;
  localparam int CNT_MAX_BITS  = 9;

  // result queue
  localparam int RES_DEPTH    = 4;
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  // per-request control, decided by the front end
  typedef struct packed {
    logic                     full;
    logic [SLOT_MAX_BITS-1:0] slot;
    logic [CNT_MAX_BITS-1:0]  div;
  } req_ctl_t;

endpackage

/* sv/vma_ram.sv */
module vma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/vma_fifo.sv */
module vma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic                do_push;
  logic                do_pop;

  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_BITS'(DEPTH - 1)) ? '0 : wptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_BITS'(DEPTH - 1)) ? '0 : rptr + PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/vma_front.sv */
module vma_front
  import vma_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  input  logic                     accept,
  output req_ctl_t                 req_ctl,
  output logic                     cfg_clear
);

  localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_BITS = $clog2(MAX_WINDOW);

  logic [WIN_LEN_BITS-1:0] win_len;
  logic [CNT_BITS-1:0]     fill;
  logic [CNT_BITS-1:0]     fill_inc;
  logic [CNT_BITS-1:0]     win;
  logic [SLOT_BITS-1:0]    oldest;
  logic [SLOT_BITS-1:0]    oldest_adv;
  logic [SLOT_BITS-1:0]    slot;
  logic                    win_full;
  logic                    reg_sel;

  assign reg_sel   = (paddr[2] == REG_WINDOW_LEN);
  assign cfg_clear = psel & penable & pwrite & reg_sel;
  assign prdata    = reg_sel ? APB_DATA_BITS'(win_len) : '0;

  // zero acts as one, oversize clamps to the ring depth
  always_comb begin
    if (win_len == '0) begin
      win = CNT_BITS'(1);
    end else if (32'(win_len) > MAX_WINDOW) begin
      win = CNT_BITS'(MAX_WINDOW);
    end else begin
      win = CNT_BITS'(win_len);
    end
  end

  // oldest stays at zero until the window fills, so a growing window
  // writes at the fill count
  assign win_full   = (fill == win);
  assign fill_inc   = fill + CNT_BITS'(1);
  assign slot       = win_full ? oldest : fill[SLOT_BITS-1:0];
  assign oldest_adv = (32'(oldest) + 1 >= 32'(win)) ? '0 : oldest + SLOT_BITS'(1);

  always_comb begin
    req_ctl.full = win_full;
    req_ctl.slot = SLOT_MAX_BITS'(slot);
    req_ctl.div  = CNT_MAX_BITS'(win_full ? fill : fill_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WIN_LEN_BITS'(WIN_LEN_RESET);
      fill    <= '0;
      oldest  <= '0;
    end else if (cfg_clear) begin
      win_len <= pwdata[WIN_LEN_BITS-1:0];
      fill    <= '0;
      oldest  <= '0;
    end else if (accept) begin
      if (win_full) begin
        oldest <= oldest_adv;
      end else begin
        fill <= fill_inc;
      end
    end
  end

endmodule

/* sv/vma_back.sv */
module vma_back
  import vma_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         req_empty,
  input  logic [LANES*SAMPLE_BITS-1:0] req_row,
  input  req_ctl_t                     req_ctl,
  output logic                         req_pop,
  input  logic [RES_CNT_BITS-1:0]      res_count,
  output logic                         res_push,
  output logic [LANES*SAMPLE_BITS-1:0] res_row
);

  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int SHIFT      = TOTAL_BITS + $clog2(MAX_WINDOW);
  localparam int REC_BITS   = SHIFT + 1;
  localparam int PROD_BITS  = TOTAL_BITS + REC_BITS;
  localparam int ROW_BITS   = LANES * SAMPLE_BITS;

  // reciprocal table: ceil(2^SHIFT / d) gives an exact floor quotient
  // for every magnitude the totals can reach
  logic [REC_BITS-1:0] recip_tab [MAX_WINDOW+1];

  assign recip_tab[0] = '0;
  for (genvar d = 1; d <= MAX_WINDOW; d++) begin : g_recip
    localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(d) - 64'd1) / 64'(d);
    assign recip_tab[d] = REC_BITS'(RECIP);
  end

  // read stage
  logic                 start;
  logic                 room;
  logic                 rd_v;
  logic [ROW_BITS-1:0]  rd_row;
  logic                 rd_full;
  logic [SLOT_BITS-1:0] rd_slot;
  logic [CNT_BITS-1:0]  rd_div;
  logic [ROW_BITS-1:0]  old_row;

  // accumulate stage
  logic signed [TOTAL_BITS-1:0] totals    [LANES];
  logic signed [TOTAL_BITS-1:0] total_new [LANES];
  logic        [TOTAL_BITS-1:0] mag_new   [LANES];

  // multiply stage
  logic                  mul_v;
  logic [TOTAL_BITS-1:0] mag [LANES];
  logic [LANES-1:0]      mul_neg;
  logic [REC_BITS-1:0]   rec;

  // sign stage
  logic                  q_v;
  logic [TOTAL_BITS-1:0] quo [LANES];
  logic [LANES-1:0]      q_neg;

  // credit: everything in flight must fit in the result queue
  assign room    = (32'(res_count) + 32'(rd_v) + 32'(mul_v) + 32'(q_v)) < RES_DEPTH;
  // a read starts only with no write-back pending, so the write-back lands before the next read
  assign start   = ~req_empty & ~rd_v & room;
  assign req_pop = start;

  vma_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (rd_v),
    .waddr(rd_slot),
    .wdata(rd_row),
    .re   (start),
    .raddr(req_ctl.slot[SLOT_BITS-1:0]),
    .rdata(old_row)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      rd_row  <= req_row;
      rd_full <= req_ctl.full;
      rd_slot <= req_ctl.slot[SLOT_BITS-1:0];
      rd_div  <= req_ctl.div[CNT_BITS-1:0];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [SAMPLE_BITS-1:0] s_new;
    logic signed [SAMPLE_BITS-1:0] s_old;
    logic signed [TOTAL_BITS-1:0]  s_sub;
    logic        [PROD_BITS-1:0]   prod;
    logic        [TOTAL_BITS-1:0]  q_neg_val;

    assign s_new      = rd_row[l*SAMPLE_BITS +: SAMPLE_BITS];
    assign s_old      = old_row[l*SAMPLE_BITS +: SAMPLE_BITS];
    assign s_sub      = rd_full ? TOTAL_BITS'(s_old) : '0;
    assign total_new[l] = totals[l] - s_sub + TOTAL_BITS'(s_new);
    assign mag_new[l] = total_new[l][TOTAL_BITS-1] ? TOTAL_BITS'(-total_new[l])
                                                   : total_new[l];

    assign prod       = PROD_BITS'(mag[l]) * PROD_BITS'(rec);
    assign q_neg_val  = q_neg[l] ? -quo[l] : quo[l];
    assign res_row[l*SAMPLE_BITS +: SAMPLE_BITS] = q_neg_val[SAMPLE_BITS-1:0];

    always_ff @(posedge clk) begin
      if (rst || clear) begin
        totals[l] <= '0;
      end else if (rd_v) begin
        totals[l] <= total_new[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rd_v) begin
        mag[l]     <= mag_new[l];
        mul_neg[l] <= total_new[l][TOTAL_BITS-1];
      end
      if (mul_v) begin
        quo[l]   <= prod[SHIFT +: TOTAL_BITS];
        q_neg[l] <= mul_neg[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      rec <= recip_tab[rd_div];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      q_v   <= 1'b0;
    end else begin
      rd_v  <= start;
      mul_v <= rd_v;
      q_v   <= mul_v;
    end
  end

  assign res_push = q_v;

endmodule

/* sv/vector_moving_average.sv */
// Channel    | Direction | Handshake                  | Payload
// ---------- | --------- | -------------------------- | -----------------------------
// samples    | in        | push / full                | sample_0 .. sample_7
// averages   | out       | pop / empty                | avg_0 .. avg_7
// config     | in/out    | APB psel/penable/pready    | window_len at byte address 0
//
// Requests: a new request starts only after the last one's history RAM row is
// written back; each reads its row, then writes it back in the next cycle.
// Path: request queue, then the read, multiply and sign stages, then result queue.
// Reset: synchronous, active high; window_len returns to 50, the window is
// empty. The history RAM needs no clearing pass and the block is ready at once.
// Stalls: a 2-entry request queue and a 4-entry result queue decouple the sides.
module vector_moving_average
  import vma_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  // samples in
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_0,
  input  logic signed [SAMPLE_BITS-1:0] sample_1,
  input  logic signed [SAMPLE_BITS-1:0] sample_2,
  input  logic signed [SAMPLE_BITS-1:0] sample_3,
  input  logic signed [SAMPLE_BITS-1:0] sample_4,
  input  logic signed [SAMPLE_BITS-1:0] sample_5,
  input  logic signed [SAMPLE_BITS-1:0] sample_6,
  input  logic signed [SAMPLE_BITS-1:0] sample_7,
  // averages out
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] avg_0,
  output logic signed [SAMPLE_BITS-1:0] avg_1,
  output logic signed [SAMPLE_BITS-1:0] avg_2,
  output logic signed [SAMPLE_BITS-1:0] avg_3,
  output logic signed [SAMPLE_BITS-1:0] avg_4,
  output logic signed [SAMPLE_BITS-1:0] avg_5,
  output logic signed [SAMPLE_BITS-1:0] avg_6,
  output logic signed [SAMPLE_BITS-1:0] avg_7
);

  localparam int ROW_BITS     = LANES * SAMPLE_BITS;
  localparam int REQ_BITS     = $bits(req_ctl_t) + ROW_BITS;
  localparam int REQ_DEPTH    = 2;
  localparam int REQ_CNT_BITS = $clog2(REQ_DEPTH + 1);

  logic                    accept;
  logic                    cfg_clear;
  req_ctl_t                front_ctl;
  logic [ROW_BITS-1:0]     in_row;

  logic [REQ_BITS-1:0]     req_head;
  req_ctl_t                head_ctl;
  logic [ROW_BITS-1:0]     head_row;
  logic                    req_empty;
  logic                    req_pop;
  logic [REQ_CNT_BITS-1:0] req_count;

  logic                    res_push;
  logic                    res_full;
  logic [ROW_BITS-1:0]     res_row;
  logic [ROW_BITS-1:0]     out_row;
  logic [RES_CNT_BITS-1:0] res_count;

  assign pready = 1'b1;
  assign accept = push & ~full;

  // lane 0 sits in the low bits of every row
  assign in_row = {sample_7, sample_6, sample_5, sample_4,
                   sample_3, sample_2, sample_1, sample_0};

  // Front end: register port and window bookkeeping. Each accepted request
  // leaves here tagged with its ring slot, whether it evicts the oldest
  // sample, and the divisor for its averages.
  vma_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .accept   (accept),
    .req_ctl  (front_ctl),
    .cfg_clear(cfg_clear)
  );

  // Request queue between the two halves; its full flag is the input
  // side's backpressure.
  vma_fifo #(
    .WIDTH(REQ_BITS),
    .DEPTH(REQ_DEPTH)
  ) u_req_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({front_ctl, in_row}),
    .full (full),
    .pop  (req_pop),
    .rdata(req_head),
    .empty(req_empty),
    .count(req_count)
  );

  assign {head_ctl, head_row} = req_head;

  // Back end: ring read, running totals, reciprocal divide, sign fix-up.
  // It only starts a request when the result queue has room for it.
  vma_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_clear),
    .req_empty(req_empty),
    .req_row  (head_row),
    .req_ctl  (head_ctl),
    .req_pop  (req_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res_row  (res_row)
  );

  // Result queue; its head drives the average ports.
  vma_fifo #(
    .WIDTH(ROW_BITS),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_row),
    .full (res_full),
    .pop  (pop),
    .rdata(out_row),
    .empty(empty),
    .count(res_count)
  );

  assign avg_0 = out_row[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_1 = out_row[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_2 = out_row[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_3 = out_row[3*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_4 = out_row[4*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_5 = out_row[5*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_6 = out_row[6*SAMPLE_BITS +: SAMPLE_BITS];
  assign avg_7 = out_row[7*SAMPLE_BITS +: SAMPLE_BITS];

  // the credit check must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> ~res_full)
    else $error("result queue pushed while full");

  // back end never takes a request from an empty queue
  a_req_pop_valid: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> ~req_empty)
    else $error("request popped from empty queue");

  // ring read and write-back alternate: no two pops in a row
  a_req_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    req_pop |=> ~req_pop)
    else $error("back-to-back request pops");

  // request queue occupancy stays within its depth
  a_req_count_bound: assert property (@(posedge clk) disable iff (rst)
    req_count <= REQ_CNT_BITS'(REQ_DEPTH))
    else $error("request queue count out of range");

endmodule

/* sim/avg_checker.sv */
module avg_checker
  import vma_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  input  logic [APB_DATA_BITS-1:0]      prdata,
  input  logic                          push,
  input  logic                          full,
  input  logic [LANES-1:0][15:0]        samples,
  input  logic                          pop,
  input  logic                          empty,
  input  logic [LANES-1:0][15:0]        avgs,
  output int                            outstanding,
  output int                            mismatches,
  output int                            averages_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN     = 64;
  localparam int SAMPLE_BITS = 16;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lane_vec_t;

  lane_vec_t                     expected_avgs[$];
  logic signed [SAMPLE_BITS-1:0] history[LANES][MAX_WIN];
  int                            lane_sum[LANES];
  int                            filled;
  int                            oldest;
  logic [WIN_LEN_BITS-1:0]       win_len;

  // zero acts as one, anything past the ring depth is clamped
  function automatic int span();
    if (win_len == '0) return 1;
    if (int'(win_len) > MAX_WIN) return MAX_WIN;
    return int'(win_len);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < LANES; i++) lane_sum[i] = 0;
    filled = 0;
    oldest = 0;
  endfunction

  function automatic lane_vec_t predict_averages(lane_vec_t s);
    int        w;
    int        slot;
    bit        at_capacity;
    lane_vec_t res;
    w = span();
    if (oldest >= w) oldest = 0;
    if (filled > w) filled = w;
    at_capacity = (filled == w);
    if (at_capacity) begin
      slot = oldest;
    end else begin
      slot = oldest + filled;
      if (slot >= w) slot -= w;
    end
    for (int i = 0; i < LANES; i++) begin
      if (at_capacity) lane_sum[i] -= int'(history[i][slot]);
      history[i][slot] = $signed(s[i]);
      lane_sum[i] += int'($signed(s[i]));
    end
    if (at_capacity) begin
      oldest++;
      if (oldest >= w) oldest = 0;
    end else begin
      filled++;
    end
    // int division truncates toward zero
    for (int i = 0; i < LANES; i++) res[i] = SAMPLE_BITS'(lane_sum[i] / filled);
    return res;
  endfunction

  function automatic void flag(string msg);
    if (mismatches < 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    lane_vec_t head;
    lane_vec_t pred;
    if (rst) begin
      expected_avgs.delete();
      win_len = WIN_LEN_BITS'(WIN_LEN_RESET);
      clear_window();
      mismatches = 0;
      averages_checked = 0;
    end else begin
      if (psel && penable && pready && paddr[APB_ADDR_BITS-1:2] == REG_WINDOW_LEN) begin
        if (pwrite) begin
          win_len = pwdata[WIN_LEN_BITS-1:0];
          clear_window();
        end else if (prdata !== APB_DATA_BITS'(win_len)) begin
          flag($sformatf("window_len read: expected %0d got %0h", win_len, prdata));
        end
      end
      if (pop && !empty) begin
        averages_checked++;
        if (expected_avgs.size() == 0) begin
          flag("average vector popped with no request outstanding");
        end else begin
          head = expected_avgs.pop_front();
          for (int i = 0; i < LANES; i++)
            if (avgs[i] !== head[i])
              flag($sformatf("avg_%0d: expected %0d got %0d",
                             i, $signed(head[i]), $signed(avgs[i])));
        end
      end
      if (push && !full) begin
        pred = predict_averages(samples);
        expected_avgs = {expected_avgs, pred};
      end
    end
    outstanding <= expected_avgs.size();
  end

endmodule

/* sim/testbench.sv */
module testbench
  import vma_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LANES-1:0][15:0] lane_vec_t;

  // window_len sits at byte address 0
  localparam logic [APB_ADDR_BITS-1:0] WIN_ADDR = {REG_WINDOW_LEN, 2'b00};
  localparam int HOLD_CYCLES = 300;   // long output stall, backs up the input side
  localparam int ITEM_TARGET = 1500;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  wire  [APB_DATA_BITS-1:0] prdata;
  wire                      pready;
  logic                     push;
  wire                      full;
  logic [LANES-1:0][15:0]   lanes_in;
  wire                      empty;
  logic                     pop;
  wire  [LANES-1:0][15:0]   avg_out;

  int outstanding;
  int mismatches;
  int averages_checked;

  int items_sent;
  int burst_left;
  int full_cycles;
  int settings_used;
  bit hold_req;
  bit hold_taken;

  vector_moving_average u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .full    (full),
    .sample_0(lanes_in[0]),
    .sample_1(lanes_in[1]),
    .sample_2(lanes_in[2]),
    .sample_3(lanes_in[3]),
    .sample_4(lanes_in[4]),
    .sample_5(lanes_in[5]),
    .sample_6(lanes_in[6]),
    .sample_7(lanes_in[7]),
    .empty   (empty),
    .pop     (pop),
    .avg_0   (avg_out[0]),
    .avg_1   (avg_out[1]),
    .avg_2   (avg_out[2]),
    .avg_3   (avg_out[3]),
    .avg_4   (avg_out[4]),
    .avg_5   (avg_out[5]),
    .avg_6   (avg_out[6]),
    .avg_7   (avg_out[7])
  );

  // watches all three channels, predicts and compares
  avg_checker u_avg_chk (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .push            (push),
    .full            (full),
    .samples         (lanes_in),
    .pop             (pop),
    .empty           (empty),
    .avgs            (avg_out),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .averages_checked(averages_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #5_000_000;
    $display("vector_moving_average test failed");
    $finish;
  end

  // Sample mix: rails, small values around zero, and full-range noise.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lane_vec_t rand_vec();
    lane_vec_t r;
    for (int i = 0; i < LANES; i++) r[i] = rand_sample();
    return r;
  endfunction

  // Offer one request and hold it until accepted. Between bursts push drops
  // for a random gap; the lanes carry junk then, which the block must ignore.
  task automatic send_item(lane_vec_t v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      push     <= 1'b0;
      lanes_in <= rand_vec();
      repeat (gap) @(posedge clk);
      // one burst in four is long, so stretches with no gaps show up too
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    push     <= 1'b1;
    lanes_in <= v;
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    items_sent++;
    burst_left--;
  endtask

  // Stop offering and wait until every predicted average has been popped.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the transfer lands on the edge with pready.
  task automatic apb_access(bit wr, logic [APB_DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WIN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Only touched while idle. Upper data bits are junk the register must drop;
  // the read-back is checked against the stored 7 bits.
  task automatic set_window(logic [WIN_LEN_BITS-1:0] len);
    drain();
    apb_access(1'b1, ($urandom & ~32'h7F) | APB_DATA_BITS'(len));
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  // Receiver: pop pattern is redrawn after each random run (always, half,
  // one in four, mostly). Once asked, it holds off for HOLD_CYCLES.
  initial begin
    int mode;
    int left;
    pop  = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int        phase;
    int        n;
    int        eff;
    logic [WIN_LEN_BITS-1:0] len;
    logic [WIN_LEN_BITS-1:0] first_lens[8];

    first_lens = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd3, 7'd2, 7'd50};
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    push     = 1'b0;
    lanes_in = '0;
    items_sent    = 0;
    burst_left    = 0;
    full_cycles   = 0;
    settings_used = 0;
    hold_req      = 1'b0;
    hold_taken    = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset value of window_len should read back as 50
    apb_access(1'b0, '0);

    // --- directed ---
    // reset window (50), never fills here: rails, all ones, bit patterns
    send_item({LANES{16'h7FFF}});
    send_item({LANES{16'h8000}});
    send_item({LANES{16'hFFFF}});
    send_item({LANES{16'h0001}});
    send_item({4{16'h5555, 16'hAAAA}});
    send_item({4{16'h8000, 16'h7FFF}});

    // zero length behaves as a window of one
    set_window(7'd0);
    send_item({LANES{16'h7FFF}});
    send_item({LANES{16'h8000}});
    send_item({4{16'hAAAA, 16'h5555}});

    // window of two: negative odd totals truncate toward zero, then wrap
    set_window(7'd2);
    send_item({LANES{-16'sd3}});
    send_item({LANES{-16'sd2}});
    send_item({LANES{16'sd1}});
    send_item({LANES{16'h8000}});

    set_window(7'd1);
    send_item({LANES{16'h8000}});
    send_item({LANES{16'h7FFF}});

    // oversized lengths clamp to the ring depth
    set_window(7'd127);
    send_item({LANES{16'h7FFF}});
    send_item({LANES{16'h8000}});
    send_item({LANES{16'hFFFF}});

    set_window(7'd65);
    send_item({LANES{16'h8000}});
    send_item({LANES{16'h0000}});

    // --- random phases: each one runs well past a full window so the
    // ring wraps at least once before the next write empties it ---
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 8) begin
        len = first_lens[phase];
      end else begin
        case ($urandom_range(0, 3))
          0:       len = WIN_LEN_BITS'($urandom_range(1, 8));
          1:       len = WIN_LEN_BITS'($urandom_range(0, 127));
          default: len = WIN_LEN_BITS'($urandom_range(1, 64));
        endcase
      end
      eff = (len == 0) ? 1 : (int'(len) > 64) ? 64 : int'(len);
      n   = 2 * eff + $urandom_range(5, 40);
      set_window(len);
      // deep-window phase: receiver stalls long while requests keep coming
      if (phase == 2) hold_req = 1'b1;
      repeat (n) send_item(rand_vec());
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d sample requests and %0d average vectors over %0d window writes",
             items_sent, averages_checked, settings_used);
    $display("(lengths 0 to 127, clamps on both ends); input held off for %0d cycles",
             full_cycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("vector_moving_average test passed");
    end else begin
      $display("vector_moving_average test failed");
    end
    $finish;
  end

endmodule
